// ----- design/assert_macros.svh -----
// Assertion macros, used by bill_of_materials_expansion.
// No dependencies; the files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that cons holds in the same cycle as ante
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- design/bom_pkg.sv -----
// Shared constants, codes and sequencer states for the bill-of-materials expansion.
// No dependencies; used by the top level.
package bom_pkg;

    localparam int MAX_PARTS  = 64;
    localparam int MAX_EDGES  = 256;

    localparam int PART_IDX_W = $clog2(MAX_PARTS);
    localparam int EDGE_IDX_W = $clog2(MAX_EDGES);
    localparam int EDGE_CNT_W = EDGE_IDX_W + 1;

    localparam int PC_W       = 7;
    localparam int QTY_W      = 8;
    localparam int PEND_W     = 8;
    localparam int COUNT_W    = 32;
    localparam int EDGE_W     = 2 * PART_IDX_W + QTY_W;

    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_LSB = 2;

    localparam logic OP_ADD     = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic REG_PART_COUNT = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_INIT,
        ST_N_RD,
        ST_N_CHK,
        ST_E_RD,
        ST_E_CHK,
        ST_E_UPD,
        ST_M_SCAN,
        ST_M_LOAD,
        ST_M_WAIT,
        ST_CLR
    } state_t;

endpackage

// ----- design/bom_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instantiated by the top level for each store.
module bom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/bill_of_materials_expansion.sv -----
// Bill-of-materials expansion: edge store, pending counts and need totals in RAMs, walked by
// one sequencer with one saturating multiply-add unit. Uses bom_pkg, bom_ram. Add: ST_ADD.
// Compute: ST_INIT setup; per pass ST_N_RD, ST_N_CHK per node, per expanded node ST_E_RD,
// ST_E_CHK per stored line plus ST_E_UPD per matching line, until a pass expands nothing;
// then ST_M_SCAN per part, ST_M_LOAD, ST_M_WAIT per base part out, ST_CLR. Not ready meanwhile.
// Reset: asynchronous, active low; clears all stores' valid bits and counts, part_count 64.
`include "assert_macros.svh"

module bill_of_materials_expansion (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bom_pkg::PADDR_W-1:0]  paddr,
    input  logic [bom_pkg::DATA_W-1:0]   pwdata,
    output logic [bom_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         operation,
    input  logic [bom_pkg::PC_W-1:0]     assembly,
    input  logic [bom_pkg::PC_W-1:0]     part,
    input  logic [bom_pkg::QTY_W-1:0]    quantity,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bom_pkg::PC_W-1:0]     part_id,
    output logic [bom_pkg::COUNT_W-1:0]  base_count,
    output logic                         last
);

    localparam int PI_W = bom_pkg::PART_IDX_W;
    localparam int EI_W = bom_pkg::EDGE_IDX_W;
    localparam int EC_W = bom_pkg::EDGE_CNT_W;
    localparam int CW   = bom_pkg::COUNT_W;
    localparam int PW   = bom_pkg::PEND_W;
    localparam int NP   = bom_pkg::MAX_PARTS;

    function automatic logic [CW-1:0] sat_mul(input logic [CW-1:0] a,
                                              input logic [bom_pkg::QTY_W-1:0] b);
        logic [CW+bom_pkg::QTY_W-1:0] p;
        p = {{bom_pkg::QTY_W{1'b0}}, a} * {{CW{1'b0}}, b};
        return (|p[CW+bom_pkg::QTY_W-1:CW]) ? '1 : p[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? '1 : s[CW-1:0];
    endfunction

    // control registers
    bom_pkg::state_t state_reg, state_next;
    logic [bom_pkg::PC_W-1:0] part_count_reg;
    logic [EC_W-1:0] edge_count_reg, edge_count_next;
    logic [NP-1:0]   has_parts_reg, has_parts_next;
    logic [NP-1:0]   done_reg, done_next;
    logic [NP-1:0]   pend_valid_reg, pend_valid_next;
    logic [NP-1:0]   need_valid_reg, need_valid_next;
    logic [PI_W-1:0] node_reg, node_next;
    logic [EI_W-1:0] edge_idx_reg, edge_idx_next;
    logic            changed_reg, changed_next;
    logic            pend_rvalid_reg, pend_rvalid_next;
    logic            need_rvalid_reg, need_rvalid_next;
    logic            out_valid_reg, out_valid_next;

    // payload registers
    logic [CW-1:0]   need_i_reg, need_i_next;
    logic [CW-1:0]   prod_reg, prod_next;
    logic [PI_W-1:0] cur_p_reg, cur_p_next;
    logic [bom_pkg::PC_W-1:0]  asm_reg, asm_next;
    logic [bom_pkg::PC_W-1:0]  part_reg, part_next;
    logic [bom_pkg::QTY_W-1:0] qty_reg, qty_next;
    logic [bom_pkg::PC_W-1:0]  out_part_id_reg, out_part_id_next;
    logic [CW-1:0]   out_count_reg, out_count_next;
    logic            out_last_reg, out_last_next;

    // RAM ports
    logic                      edge_we;
    logic [EI_W-1:0]           edge_waddr, edge_raddr;
    logic [bom_pkg::EDGE_W-1:0] edge_wdata, edge_q;
    logic                      pend_we;
    logic [PI_W-1:0]           pend_waddr, pend_raddr;
    logic [PW-1:0]             pend_wdata, pend_q, pend_rd;
    logic                      need_we;
    logic [PI_W-1:0]           need_waddr, need_raddr;
    logic [CW-1:0]             need_wdata, need_q, need_rd;

    // derived values
    logic [bom_pkg::PC_W-1:0]  pc_eff, pc_m1, asm_m1, part_m1, in_part_m1;
    logic [PI_W-1:0]           pc_last;
    logic                      add_ok, accept, cfg_wr, base_above, edge_end;
    logic [PI_W-1:0]           e_asm, e_part;
    logic [bom_pkg::QTY_W-1:0] e_qty;
    logic [EC_W-1:0]           edge_idx_inc;
    bom_pkg::state_t           adv_state;
    logic [PI_W-1:0]           adv_node;
    logic                      adv_changed;

    bom_ram #(.WIDTH(bom_pkg::EDGE_W), .DEPTH(bom_pkg::MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_q)
    );

    bom_ram #(.WIDTH(PW), .DEPTH(NP)) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .raddr (pend_raddr),
        .rdata (pend_q)
    );

    bom_ram #(.WIDTH(CW), .DEPTH(NP)) u_need_ram (
        .clk   (clk),
        .we    (need_we),
        .waddr (need_waddr),
        .wdata (need_wdata),
        .raddr (need_raddr),
        .rdata (need_q)
    );

    assign pend_rd = pend_rvalid_reg ? pend_q : '0;
    assign need_rd = need_rvalid_reg ? need_q : '0;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[bom_pkg::REG_IDX_LSB] == bom_pkg::REG_PART_COUNT);

    always_comb
    begin
        unique case (paddr[bom_pkg::REG_IDX_LSB])
            bom_pkg::REG_PART_COUNT:
                prdata = {{(bom_pkg::DATA_W - bom_pkg::PC_W){1'b0}}, part_count_reg};
            default:
                prdata = '0;
        endcase
    end

    // clamp part count
    always_comb
    begin
        if (part_count_reg < bom_pkg::PC_W'(2))
        begin
            pc_eff = bom_pkg::PC_W'(2);
        end
        else if (part_count_reg > bom_pkg::PC_W'(NP))
        begin
            pc_eff = bom_pkg::PC_W'(NP);
        end
        else
        begin
            pc_eff = part_count_reg;
        end
    end

    assign pc_m1      = pc_eff - bom_pkg::PC_W'(1);
    assign pc_last    = pc_m1[PI_W-1:0];
    assign asm_m1     = asm_reg - bom_pkg::PC_W'(1);
    assign part_m1    = part_reg - bom_pkg::PC_W'(1);
    assign in_part_m1 = part - bom_pkg::PC_W'(1);

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != bom_pkg::ST_IDLE);

    assign add_ok = (asm_reg != '0) && (asm_reg <= pc_eff) &&
                    (part_reg != '0) && (part_reg <= pc_eff) &&
                    (edge_count_reg != EC_W'(bom_pkg::MAX_EDGES)) &&
                    (pend_rd != '1);

    assign e_asm  = edge_q[bom_pkg::EDGE_W-1 -: PI_W];
    assign e_part = edge_q[bom_pkg::QTY_W +: PI_W];
    assign e_qty  = edge_q[bom_pkg::QTY_W-1:0];

    assign edge_idx_inc = {1'b0, edge_idx_reg} + EC_W'(1);
    assign edge_end     = (edge_idx_inc == edge_count_reg);

    // advance to the next node, or close the pass
    always_comb
    begin
        if (node_reg == pc_last)
        begin
            adv_node    = '0;
            adv_changed = 1'b0;
            adv_state   = changed_reg ? bom_pkg::ST_N_RD : bom_pkg::ST_M_SCAN;
        end
        else
        begin
            adv_node    = node_reg + PI_W'(1);
            adv_changed = changed_reg;
            adv_state   = bom_pkg::ST_N_RD;
        end
    end

    // any base part in use above the current one
    always_comb
    begin
        base_above = 1'b0;
        for (int k = 0; k < NP; k++)
        begin
            if (!has_parts_reg[k] && (PI_W'(k) <= pc_last) && (PI_W'(k) > node_reg))
            begin
                base_above = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        edge_count_next  = edge_count_reg;
        has_parts_next   = has_parts_reg;
        done_next        = done_reg;
        pend_valid_next  = pend_valid_reg;
        need_valid_next  = need_valid_reg;
        node_next        = node_reg;
        edge_idx_next    = edge_idx_reg;
        changed_next     = changed_reg;
        out_valid_next   = out_valid_reg;
        need_i_next      = need_i_reg;
        prod_next        = prod_reg;
        cur_p_next       = cur_p_reg;
        asm_next         = asm_reg;
        part_next        = part_reg;
        qty_next         = qty_reg;
        out_part_id_next = out_part_id_reg;
        out_count_next   = out_count_reg;
        out_last_next    = out_last_reg;

        edge_we    = 1'b0;
        edge_waddr = edge_count_reg[EI_W-1:0];
        edge_wdata = {asm_m1[PI_W-1:0], part_m1[PI_W-1:0], qty_reg};
        edge_raddr = edge_idx_reg;
        pend_we    = 1'b0;
        pend_waddr = cur_p_reg;
        pend_wdata = pend_rd - PW'(1);
        pend_raddr = node_reg;
        need_we    = 1'b0;
        need_waddr = cur_p_reg;
        need_wdata = sat_add(need_rd, prod_reg);
        need_raddr = node_reg;

        unique case (state_reg)
            bom_pkg::ST_IDLE:
            begin
                pend_raddr = in_part_m1[PI_W-1:0];
                if (accept)
                begin
                    asm_next  = assembly;
                    part_next = part;
                    qty_next  = quantity;
                    state_next = (operation == bom_pkg::OP_COMPUTE) ?
                                 bom_pkg::ST_INIT : bom_pkg::ST_ADD;
                end
            end

            bom_pkg::ST_ADD:
            begin
                pend_waddr = part_m1[PI_W-1:0];
                pend_wdata = pend_rd + PW'(1);
                if (add_ok)
                begin
                    edge_we = 1'b1;
                    pend_we = 1'b1;
                    pend_valid_next[part_m1[PI_W-1:0]] = 1'b1;
                    has_parts_next[asm_m1[PI_W-1:0]]   = 1'b1;
                    edge_count_next = edge_count_reg + EC_W'(1);
                end
                state_next = bom_pkg::ST_IDLE;
            end

            bom_pkg::ST_INIT:
            begin
                need_we    = 1'b1;
                need_waddr = pc_last;
                need_wdata = CW'(1);
                need_valid_next[pc_last] = 1'b1;
                node_next    = '0;
                changed_next = 1'b0;
                state_next   = bom_pkg::ST_N_RD;
            end

            bom_pkg::ST_N_RD:
            begin
                state_next = bom_pkg::ST_N_CHK;
            end

            bom_pkg::ST_N_CHK:
            begin
                if ((pend_rd == '0) && !done_reg[node_reg])
                begin
                    need_i_next = need_rd;
                    if (edge_count_reg != '0)
                    begin
                        edge_idx_next = '0;
                        state_next    = bom_pkg::ST_E_RD;
                    end
                    else
                    begin
                        done_next[node_reg] = 1'b1;
                        node_next    = adv_node;
                        changed_next = adv_changed;
                        state_next   = adv_state;
                    end
                end
                else
                begin
                    node_next    = adv_node;
                    changed_next = adv_changed;
                    state_next   = adv_state;
                end
            end

            bom_pkg::ST_E_RD:
            begin
                state_next = bom_pkg::ST_E_CHK;
            end

            bom_pkg::ST_E_CHK:
            begin
                pend_raddr = e_part;
                need_raddr = e_part;
                if (e_asm == node_reg)
                begin
                    changed_next = 1'b1;
                    prod_next    = sat_mul(need_i_reg, e_qty);
                    cur_p_next   = e_part;
                    state_next   = bom_pkg::ST_E_UPD;
                end
                else if (edge_end)
                begin
                    done_next[node_reg] = 1'b1;
                    node_next    = adv_node;
                    changed_next = adv_changed;
                    state_next   = adv_state;
                end
                else
                begin
                    edge_idx_next = edge_idx_inc[EI_W-1:0];
                    state_next    = bom_pkg::ST_E_RD;
                end
            end

            bom_pkg::ST_E_UPD:
            begin
                need_we = 1'b1;
                pend_we = 1'b1;
                if (pend_rd == '0)
                begin
                    pend_wdata = '0;
                end
                need_valid_next[cur_p_reg] = 1'b1;
                pend_valid_next[cur_p_reg] = 1'b1;
                if (edge_end)
                begin
                    done_next[node_reg] = 1'b1;
                    node_next    = adv_node;
                    changed_next = adv_changed;
                    state_next   = adv_state;
                end
                else
                begin
                    edge_idx_next = edge_idx_inc[EI_W-1:0];
                    state_next    = bom_pkg::ST_E_RD;
                end
            end

            bom_pkg::ST_M_SCAN:
            begin
                if (!has_parts_reg[node_reg])
                begin
                    state_next = bom_pkg::ST_M_LOAD;
                end
                else if (node_reg == pc_last)
                begin
                    state_next = bom_pkg::ST_CLR;
                end
                else
                begin
                    node_next = node_reg + PI_W'(1);
                end
            end

            bom_pkg::ST_M_LOAD:
            begin
                out_valid_next   = 1'b1;
                out_part_id_next = {1'b0, node_reg} + bom_pkg::PC_W'(1);
                out_count_next   = need_rd;
                out_last_next    = !base_above;
                state_next       = bom_pkg::ST_M_WAIT;
            end

            bom_pkg::ST_M_WAIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (node_reg == pc_last)
                    begin
                        state_next = bom_pkg::ST_CLR;
                    end
                    else
                    begin
                        node_next  = node_reg + PI_W'(1);
                        state_next = bom_pkg::ST_M_SCAN;
                    end
                end
            end

            bom_pkg::ST_CLR:
            begin
                edge_count_next = '0;
                has_parts_next  = '0;
                done_next       = '0;
                pend_valid_next = '0;
                need_valid_next = '0;
                node_next       = '0;
                state_next      = bom_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = bom_pkg::ST_IDLE;
            end
        endcase

        pend_rvalid_next = pend_valid_reg[pend_raddr];
        need_rvalid_next = need_valid_reg[need_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bom_pkg::ST_IDLE;
            part_count_reg  <= bom_pkg::PC_W'(NP);
            edge_count_reg  <= '0;
            has_parts_reg   <= '0;
            done_reg        <= '0;
            pend_valid_reg  <= '0;
            need_valid_reg  <= '0;
            node_reg        <= '0;
            edge_idx_reg    <= '0;
            changed_reg     <= 1'b0;
            pend_rvalid_reg <= 1'b0;
            need_rvalid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_wr)
            begin
                part_count_reg <= pwdata[bom_pkg::PC_W-1:0];
            end
            edge_count_reg  <= edge_count_next;
            has_parts_reg   <= has_parts_next;
            done_reg        <= done_next;
            pend_valid_reg  <= pend_valid_next;
            need_valid_reg  <= need_valid_next;
            node_reg        <= node_next;
            edge_idx_reg    <= edge_idx_next;
            changed_reg     <= changed_next;
            pend_rvalid_reg <= pend_rvalid_next;
            need_rvalid_reg <= need_rvalid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_i_reg      <= need_i_next;
        prod_reg        <= prod_next;
        cur_p_reg       <= cur_p_next;
        asm_reg         <= asm_next;
        part_reg        <= part_next;
        qty_reg         <= qty_next;
        out_part_id_reg <= out_part_id_next;
        out_count_reg   <= out_count_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign part_id    = out_part_id_reg;
    assign base_count = out_count_reg;
    assign last       = out_last_reg;

    `ASSERT_IMPL(a_accept_idle, clk, rst_n, accept, state_reg == bom_pkg::ST_IDLE)
    `ASSERT_IMPL(a_pend_nonzero, clk, rst_n, state_reg == bom_pkg::ST_E_UPD, pend_rd != '0)
    `ASSERT_IMPL(a_edge_bound, clk, rst_n, 1'b1, edge_count_reg <= EC_W'(bom_pkg::MAX_EDGES))
    `ASSERT_NEXT(a_clear_job, clk, rst_n, state_reg == bom_pkg::ST_CLR,
                 (edge_count_reg == '0) && (done_reg == '0) && (has_parts_reg == '0))
    `ASSERT_IMPL(a_out_wait, clk, rst_n, out_valid_reg, state_reg == bom_pkg::ST_M_WAIT)

endmodule

// ----- dv/tb_bill_of_materials_expansion.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bill_of_materials_expansion: recipe jobs under several part_count
// settings, each base-part result checked against an in-bench expansion of the same job.
// Depends on bom_pkg and the design sources; reads no files.
module tb_bill_of_materials_expansion;

    localparam int PC_W      = bom_pkg::PC_W;
    localparam int QTY_W     = bom_pkg::QTY_W;
    localparam int COUNT_W   = bom_pkg::COUNT_W;
    localparam int PADDR_W   = bom_pkg::PADDR_W;
    localparam int DATA_W    = bom_pkg::DATA_W;
    localparam int MAX_PARTS = bom_pkg::MAX_PARTS;
    localparam int MAX_EDGES = bom_pkg::MAX_EDGES;

    typedef struct {
        logic             op;
        logic [PC_W-1:0]  assembly;
        logic [PC_W-1:0]  part;
        logic [QTY_W-1:0] quantity;
    } bom_req_t;

    typedef struct {
        logic [PC_W-1:0]    part_id;
        logic [COUNT_W-1:0] base_count;
        logic               last;
    } base_line_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0]  pwdata    = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               operation = bom_pkg::OP_ADD;
    logic [PC_W-1:0]    assembly  = '0;
    logic [PC_W-1:0]    part      = '0;
    logic [QTY_W-1:0]   quantity  = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [PC_W-1:0]    part_id;
    logic [COUNT_W-1:0] base_count;
    logic               last;

    // expected job state
    logic [5:0]         line_asm    [MAX_EDGES];
    logic [5:0]         line_part   [MAX_EDGES];
    logic [QTY_W-1:0]   line_qty    [MAX_EDGES];
    int                 line_total;
    logic [7:0]         users_left  [MAX_PARTS];
    logic [COUNT_W-1:0] need        [MAX_PARTS];
    bit                 is_assembly [MAX_PARTS];
    bit                 expanded    [MAX_PARTS];
    logic [PC_W-1:0]    part_count_cfg = 7'd64;

    base_line_t         base_lines_due[$];
    base_line_t         due_line;
    bom_req_t           pending_reqs[$];
    bom_req_t           cur_req;
    bit                 req_busy;
    bit                 req_taken;
    int                 gap_left;
    int                 burst_left = 1;
    int                 stall_cyc;
    int                 quiet_cycles;
    int                 errors;
    int                 n_requests;
    int                 n_computes;
    int                 n_results;
    int                 n_settings;

    bill_of_materials_expansion uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .assembly   (assembly),
        .part       (part),
        .quantity   (quantity),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .part_id    (part_id),
        .base_count (base_count),
        .last       (last)
    );

    always #5 clk = ~clk;

    function automatic int parts_in_use(input logic [PC_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > MAX_PARTS)
            return MAX_PARTS;
        return int'(v);
    endfunction

    function automatic logic [COUNT_W-1:0] mul_clip(input logic [COUNT_W-1:0] a,
                                                    input logic [QTY_W-1:0] b);
        logic [63:0] prod;
        prod = {32'd0, a} * {56'd0, b};
        return (prod > 64'hFFFF_FFFF) ? '1 : prod[31:0];
    endfunction

    function automatic logic [COUNT_W-1:0] add_clip(input logic [COUNT_W-1:0] a,
                                                    input logic [COUNT_W-1:0] b);
        logic [63:0] sum;
        sum = {32'd0, a} + {32'd0, b};
        return (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
    endfunction

    function automatic void clear_job();
        line_total = 0;
        for (int i = 0; i < MAX_PARTS; i++)
        begin
            users_left[i]  = '0;
            need[i]        = '0;
            is_assembly[i] = 1'b0;
            expanded[i]    = 1'b0;
        end
    endfunction

    task automatic explode_request(input bom_req_t r);
        int         pc;
        int         a;
        int         p;
        int         n;
        int         passes;
        int         walked;
        int         hits;
        bit         changed;
        bit         have_held;
        base_line_t held;
        pc = parts_in_use(part_count_cfg);
        if (r.op == bom_pkg::OP_ADD)
        begin
            a = int'(r.assembly);
            p = int'(r.part);
            if (a >= 1 && a <= pc && p >= 1 && p <= pc && line_total < MAX_EDGES
                && users_left[p - 1] != 8'd255)
            begin
                line_asm[line_total]  = 6'(a - 1);
                line_part[line_total] = 6'(p - 1);
                line_qty[line_total]  = r.quantity;
                line_total++;
                users_left[p - 1]  = users_left[p - 1] + 8'd1;
                is_assembly[a - 1] = 1'b1;
            end
        end
        else
        begin
            need[pc - 1] = COUNT_W'(1);
            changed = 1'b1;
            passes  = 0;
            walked  = 0;
            hits    = 0;
            while (changed)
            begin
                changed = 1'b0;
                passes++;
                for (int i = 0; i < pc; i++)
                begin
                    if (users_left[i] == 8'd0 && !expanded[i])
                    begin
                        walked++;
                        for (int e = 0; e < line_total; e++)
                        begin
                            if (int'(line_asm[e]) == i)
                            begin
                                p = int'(line_part[e]);
                                need[p] = add_clip(need[p], mul_clip(need[i], line_qty[e]));
                                if (users_left[p] != 8'd0)
                                    users_left[p] = users_left[p] - 8'd1;
                                changed = 1'b1;
                                hits++;
                            end
                        end
                        expanded[i] = 1'b1;
                    end
                end
            end
            n = 0;
            have_held = 1'b0;
            for (int i = 0; i < pc; i++)
            begin
                if (!is_assembly[i])
                begin
                    if (have_held)
                        base_lines_due.push_back(held);
                    held.part_id    = PC_W'(i + 1);
                    held.base_count = need[i];
                    held.last       = 1'b0;
                    have_held = 1'b1;
                    n++;
                end
            end
            if (have_held)
            begin
                held.last = 1'b1;
                base_lines_due.push_back(held);
            end
            if (n == 0)
                quiet_cycles = passes * 2 * pc + walked * 2 * line_total + hits + 64;
            n_computes++;
            n_results += n;
            clear_job();
        end
    endtask

    task automatic queue_line(input int a, input int p, input int q);
        bom_req_t r;
        r.op       = bom_pkg::OP_ADD;
        r.assembly = PC_W'(a);
        r.part     = PC_W'(p);
        r.quantity = QTY_W'(q);
        pending_reqs.push_back(r);
    endtask

    task automatic queue_compute();
        bom_req_t r;
        r.op       = bom_pkg::OP_COMPUTE;
        r.assembly = PC_W'($urandom);
        r.part     = PC_W'($urandom);
        r.quantity = QTY_W'($urandom);
        pending_reqs.push_back(r);
    endtask

    task automatic write_part_count(input logic [PC_W-1:0] value);
        logic [DATA_W-1:0] upper;
        upper = $urandom_range(0, 1) ? $urandom : '0;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(bom_pkg::REG_PART_COUNT) * (1 << bom_pkg::REG_IDX_LSB));
        pwdata  <= {upper[DATA_W-1:PC_W], value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        part_count_cfg = value;
        n_settings++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drain all requests and results, then let the block go quiet
    task automatic settle();
        while (pending_reqs.size() != 0 || req_busy || base_lines_due.size() != 0)
            @(posedge clk);
        repeat (300 + quiet_cycles) @(posedge clk);
        quiet_cycles = 0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            explode_request(cur_req);
            req_taken = 1'b1;
            n_requests++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_taken)
            begin
                req_taken = 1'b0;
                req_busy  = 1'b0;
            end
            if (!req_busy)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() != 0)
                begin
                    cur_req   = pending_reqs.pop_front();
                    req_busy  = 1'b1;
                    operation <= cur_req.op;
                    assembly  <= cur_req.assembly;
                    part      <= cur_req.part;
                    quantity  <= cur_req.quantity;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            in_valid <= req_busy;
        end
    end

    always @(negedge clk)
    begin
        stall_cyc++;
        case ((stall_cyc / 256) % 4)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 1);
            2:       out_stall <= ((stall_cyc % 7) < 3);
            default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (base_lines_due.size() == 0)
            begin
                $error("unexpected result: part_id %0d base_count %0d", part_id, base_count);
                errors++;
            end
            else
            begin
                due_line = base_lines_due.pop_front();
                if (part_id !== due_line.part_id)
                begin
                    $error("part_id: expected %0d, got %0d", due_line.part_id, part_id);
                    errors++;
                end
                if (base_count !== due_line.base_count)
                begin
                    $error("base_count: expected %0d, got %0d", due_line.base_count, base_count);
                    errors++;
                end
                if (last !== due_line.last)
                begin
                    $error("last: expected %0d, got %0d", due_line.last, last);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int pc;
        int k;
        int t;
        int lines;
        int a;
        int p;
        int q;
        int r;
        int random_items;
        bit capacity_done;
        clear_job();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty store at reset width: every part is base
        queue_compute();
        settle();

        // deep chain with product and sum saturation, plus bad part numbers
        queue_line(64, 10, 255);
        queue_line(64, 11, 255);
        queue_line(10, 12, 255);
        queue_line(11, 12, 255);
        queue_line(12, 13, 255);
        queue_line(13, 1, 255);
        queue_line(13, 2, 1);
        queue_line(13, 5, 100);
        queue_line(13, 5, 100);
        queue_line(0, 3, 1);
        queue_line(3, 0, 1);
        queue_line(127, 65, 1);
        queue_compute();
        settle();

        // two parts in a loop: nothing is base
        write_part_count(PC_W'(2));
        queue_line(2, 1, 7);
        queue_line(1, 2, 3);
        queue_line(2, 3, 1);
        queue_compute();
        settle();

        write_part_count(PC_W'(0));
        queue_line(2, 1, 9);
        queue_compute();
        settle();

        // lines loaded wide, computed narrow
        write_part_count(PC_W'(127));
        queue_line(64, 3, 2);
        queue_line(3, 1, 4);
        settle();
        write_part_count(PC_W'(3));
        queue_compute();
        settle();

        write_part_count(PC_W'(1));
        queue_line(1, 2, 5);
        queue_compute();
        settle();

        random_items  = 0;
        capacity_done = 1'b0;
        while (random_items < 200)
        begin
            if (!capacity_done && random_items >= 16)
            begin
                // fill part 1 to its user limit, then the store to its end
                capacity_done = 1'b1;
                write_part_count(PC_W'(64));
                for (int j = 0; j < 256; j++)
                    queue_line($urandom_range(2, 64), 1, $urandom_range(1, 3));
                queue_line($urandom_range(3, 64), 2, $urandom_range(1, 255));
                for (int j = 0; j < 4; j++)
                    queue_line($urandom_range(4, 64), $urandom_range(3, 4), $urandom_range(1, 9));
                queue_compute();
                random_items += 262;
                settle();
            end
            else
            begin
                r = $urandom_range(0, 9);
                case (r)
                    0:          k = $urandom_range(0, 1);
                    1:          k = $urandom_range(65, 127);
                    2:          k = 64;
                    3, 4, 5:    k = $urandom_range(2, 8);
                    default:    k = $urandom_range(9, 64);
                endcase
                write_part_count(PC_W'(k));
                pc = parts_in_use(PC_W'(k));
                lines = $urandom_range(1, 24);
                for (int j = 0; j < lines; j++)
                begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                    begin
                        a = $urandom_range(0, 1) ? 0 : $urandom_range(pc + 1, 127);
                        p = $urandom_range(1, pc);
                        if ($urandom_range(0, 1))
                        begin
                            t = a;
                            a = p;
                            p = t;
                        end
                    end
                    else if (r == 1)
                    begin
                        a = $urandom_range(1, pc);
                        p = $urandom_range(1, pc);
                    end
                    else
                    begin
                        a = ($urandom_range(0, 2) == 0) ? pc : $urandom_range(2, pc);
                        p = $urandom_range(1, a - 1);
                    end
                    q = ($urandom_range(0, 7) == 0) ? $urandom_range(128, 255)
                                                    : $urandom_range(1, 9);
                    queue_line(a, p, q);
                end
                random_items += lines;
                if ($urandom_range(0, 7) != 0)
                begin
                    queue_compute();
                    random_items++;
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    queue_compute();
                    random_items++;
                end
                settle();
            end
        end

        settle();
        $display("Run covered %0d requests in %0d compute jobs, %0d base-part results checked,",
                 n_requests, n_computes, n_results);
        $display("over %0d part_count settings including both range limits.", n_settings);
        if (errors == 0 && base_lines_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
